FILE: rtl/stuffed_frame_receiver_crc16_assert.svh
// Assertion macros used by the frame receiver top module.
`ifndef STUFFED_FRAME_RECEIVER_CRC16_ASSERT_SVH
`define STUFFED_FRAME_RECEIVER_CRC16_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define SFR_ASSERT_NOW(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// A trigger in one cycle that requires a condition in the next cycle.
`define SFR_ASSERT_NEXT(name, trig, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

FILE: rtl/sfr_pkg.sv
// Shared types, constants and the CRC step function of the frame receiver.
`default_nettype none

package sfr_pkg;

	localparam int BYTE_W      = 8;
	localparam int CRC_W       = 16;
	localparam int LEN_W       = 16;
	localparam int STATUS_W    = 4;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [BYTE_W-1:0] MARKER_RESET = 8'd126;
	localparam logic [CRC_W-1:0]  MASK_RESET   = 16'hA001;
	localparam logic [LEN_W-1:0]  CRC_BYTES    = 16'd2;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_MARKER = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_CRC_MASK     = 1'b1;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_IDLE     = 4'd0;
	localparam logic [STATUS_W-1:0] ST_MARKER   = 4'd1;
	localparam logic [STATUS_W-1:0] ST_HEADER   = 4'd2;
	localparam logic [STATUS_W-1:0] ST_PAYLOAD  = 4'd3;
	localparam logic [STATUS_W-1:0] ST_CRC_BYTE = 4'd4;
	localparam logic [STATUS_W-1:0] ST_OK       = 4'd5;
	localparam logic [STATUS_W-1:0] ST_CRC_ERR  = 4'd6;
	localparam logic [STATUS_W-1:0] ST_LEN_ERR  = 4'd7;
	localparam logic [STATUS_W-1:0] ST_RESTART  = 4'd8;

	// What the front end decided about one line byte.
	typedef enum logic [1:0] {
		OP_MARK,
		OP_DATA,
		OP_START
	} sfr_op_t;

	typedef struct packed {
		sfr_op_t           op;
		logic [BYTE_W-1:0] data;
	} sfr_item_t;

	// Reflected CRC over one byte, least significant bit first.
	function automatic logic [CRC_W-1:0] crc16_byte(
		input logic [CRC_W-1:0]  crc_in,
		input logic [BYTE_W-1:0] data,
		input logic [CRC_W-1:0]  mask
	);
		logic [CRC_W-1:0] crc;
		crc = crc_in;
		for (int i = 0; i < BYTE_W; i++) begin
			if (crc[0] ^ data[i]) begin
				crc = (crc >> 1) ^ mask;
			end else begin
				crc = crc >> 1;
			end
		end
		return crc;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/sfr_ifs.sv
// Stream interfaces for the line byte input and the result output.
`default_nettype none

interface sfr_byte_if;
	logic                       valid;
	logic                       ready;
	logic [sfr_pkg::BYTE_W-1:0] byte_in;

	modport source (output valid, output byte_in, input ready);
	modport sink (input valid, input byte_in, output ready);
endinterface

interface sfr_result_if;
	logic                         valid;
	logic                         ready;
	logic [sfr_pkg::STATUS_W-1:0] status;
	logic [sfr_pkg::BYTE_W-1:0]   payload_byte;
	logic                         payload_valid;
	logic                         receiving;
	logic [sfr_pkg::LEN_W-1:0]    bytes_remaining;

	modport source (
		output valid, output status, output payload_byte, output payload_valid,
		output receiving, output bytes_remaining, input ready
	);
	modport sink (
		input valid, input status, input payload_byte, input payload_valid,
		input receiving, input bytes_remaining, output ready
	);
endinterface

`default_nettype wire

FILE: rtl/sfr_front.sv
// Destuffing front end: sorts each line byte into marker, data or frame start.
`default_nettype none

module sfr_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [sfr_pkg::BYTE_W-1:0] frame_marker,
	sfr_byte_if.sink                        rx_byte,
	output sfr_pkg::sfr_item_t              push_item,
	output logic                            push_valid,
	input  wire logic                       push_ready
);
	import sfr_pkg::*;

	logic marker_pending_q;
	logic is_marker;

	assign is_marker  = (rx_byte.byte_in == frame_marker);
	assign push_valid = rx_byte.valid;
	assign rx_byte.ready = push_ready;

	always_comb begin
		push_item.data = rx_byte.byte_in;
		if (is_marker) begin
			push_item.op = marker_pending_q ? OP_DATA : OP_MARK;
		end else begin
			push_item.op = marker_pending_q ? OP_START : OP_DATA;
		end
	end

	// A lone marker is held until the next byte tells whether it was doubled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_pending_q <= 1'b0;
		end else if (rx_byte.valid && push_ready) begin
			marker_pending_q <= is_marker && !marker_pending_q;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/sfr_queue.sv
// Small FIFO that decouples the destuffing front end from the frame decoder.
`default_nettype none

module sfr_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire sfr_pkg::sfr_item_t push_item,
	input  wire logic               push_valid,
	output logic                    push_ready,
	output sfr_pkg::sfr_item_t      pop_item,
	output logic                    pop_valid,
	input  wire logic               pop_ready
);
	import sfr_pkg::*;

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	sfr_item_t       entry_q [QUEUE_DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (count_q != CW'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/sfr_back.sv
// Frame decoder: length header, payload with CRC, CRC compare, result register.
`default_nettype none

module sfr_back (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [sfr_pkg::CRC_W-1:0] crc_mask,
	input  wire sfr_pkg::sfr_item_t        pop_item,
	input  wire logic                      pop_valid,
	output logic                           pop_ready,
	sfr_result_if.source                   result
);
	import sfr_pkg::*;

	typedef enum logic [1:0] {
		PH_WAIT,
		PH_HEADER,
		PH_PAYLOAD,
		PH_CRC
	} phase_t;

	phase_t              phase_q;
	logic                in_frame_q;
	logic                length_low_seen_q;
	logic [LEN_W-1:0]    remaining_q;
	logic [CRC_W-1:0]    crc_q;
	logic [BYTE_W-1:0]   crc_high_q;
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [BYTE_W-1:0]   payload_byte_q;
	logic                payload_valid_q;
	logic                receiving_q;
	logic [LEN_W-1:0]    bytes_remaining_q;

	phase_t              ph_d;
	logic                inf_d;
	logic                lls_d;
	logic [LEN_W-1:0]    rem_d;
	logic [CRC_W-1:0]    crc_d;
	logic [BYTE_W-1:0]   chb_d;
	logic [STATUS_W-1:0] st_d;
	logic                valid_d;
	logic                pop;

	assign pop_ready = !out_valid_q || result.ready;
	assign pop       = pop_valid && pop_ready;

	always_comb begin
		logic [BYTE_W-1:0] b;
		logic              restart;
		b       = pop_item.data;
		restart = 1'b0;
		ph_d    = phase_q;
		inf_d   = in_frame_q;
		lls_d   = length_low_seen_q;
		rem_d   = remaining_q;
		crc_d   = crc_q;
		chb_d   = crc_high_q;
		valid_d = 1'b0;
		st_d    = ST_IDLE;
		if (pop_item.op == OP_MARK) begin
			st_d = ST_MARKER;
		end else begin
			if (pop_item.op == OP_START) begin
				restart = in_frame_q;
				ph_d    = PH_HEADER;
				inf_d   = 1'b1;
				lls_d   = 1'b0;
				rem_d   = '0;
				crc_d   = '0;
				chb_d   = '0;
			end
			case (ph_d)
				PH_WAIT: begin
					lls_d = 1'b0;
					st_d  = ST_IDLE;
				end
				PH_HEADER: begin
					inf_d = 1'b1;
					st_d  = ST_HEADER;
					if (!lls_d) begin
						rem_d = {{(LEN_W-BYTE_W){1'b0}}, b};
						lls_d = 1'b1;
					end else begin
						rem_d = rem_d | {b, {(LEN_W-BYTE_W){1'b0}}};
						ph_d  = PH_PAYLOAD;
						crc_d = '0;
					end
				end
				PH_PAYLOAD: begin
					rem_d = rem_d - 1'b1;
					crc_d = crc16_byte(crc_d, b, crc_mask);
					if (rem_d < CRC_BYTES) begin
						// Length too short to hold the CRC: drop the frame.
						st_d  = ST_LEN_ERR;
						ph_d  = PH_WAIT;
						inf_d = 1'b0;
						lls_d = 1'b0;
						rem_d = '0;
						crc_d = '0;
						chb_d = '0;
					end else begin
						if (rem_d == CRC_BYTES) begin
							ph_d = PH_CRC;
						end
						valid_d = 1'b1;
						st_d    = ST_PAYLOAD;
					end
				end
				PH_CRC: begin
					if (rem_d != '0) begin
						chb_d = b;
						rem_d = '0;
						st_d  = ST_CRC_BYTE;
					end else begin
						st_d  = (crc_d == {chb_d, b}) ? ST_OK : ST_CRC_ERR;
						ph_d  = PH_WAIT;
						inf_d = 1'b0;
						lls_d = 1'b0;
						rem_d = '0;
						crc_d = '0;
						chb_d = '0;
					end
				end
				default: begin
					st_d = ST_IDLE;
				end
			endcase
			if (restart) begin
				st_d = ST_RESTART;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q           <= PH_WAIT;
			in_frame_q        <= 1'b0;
			length_low_seen_q <= 1'b0;
			remaining_q       <= '0;
			crc_q             <= '0;
			crc_high_q        <= '0;
			out_valid_q       <= 1'b0;
			status_q          <= ST_IDLE;
			payload_byte_q    <= '0;
			payload_valid_q   <= 1'b0;
			receiving_q       <= 1'b0;
			bytes_remaining_q <= '0;
		end else begin
			if (pop) begin
				phase_q           <= ph_d;
				in_frame_q        <= inf_d;
				length_low_seen_q <= lls_d;
				remaining_q       <= rem_d;
				crc_q             <= crc_d;
				crc_high_q        <= chb_d;
				out_valid_q       <= 1'b1;
				status_q          <= st_d;
				payload_byte_q    <= valid_d ? pop_item.data : '0;
				payload_valid_q   <= valid_d;
				receiving_q       <= inf_d;
				bytes_remaining_q <= inf_d ? rem_d : '0;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid           = out_valid_q;
	assign result.status          = status_q;
	assign result.payload_byte    = payload_byte_q;
	assign result.payload_valid   = payload_valid_q;
	assign result.receiving       = receiving_q;
	assign result.bytes_remaining = bytes_remaining_q;

endmodule

`default_nettype wire

FILE: rtl/stuffed_frame_receiver_crc16.sv
// Byte-stuffed frame receiver with length header and CRC-16 check.
// A result passes through the queue, then the result register, after its byte's transfer.
// Throughput: one byte per cycle unless results stall; the CRC over a byte is one combinational step per cycle.
// A two-entry queue between destuffing and decoding lets each side stall on its own.
// Reset clears all decoder state and sets the marker to 126 and the CRC mask to 0xA001.
`default_nettype none

`include "stuffed_frame_receiver_crc16_assert.svh"

module stuffed_frame_receiver_crc16 (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            wr_en,
	input  wire logic [sfr_pkg::CFG_INDEX_W-1:0] wr_index,
	input  wire logic [sfr_pkg::CFG_DATA_W-1:0]  wr_data,
	sfr_byte_if.sink                             rx_byte,
	sfr_result_if.source                         result
);
	import sfr_pkg::*;

	logic [BYTE_W-1:0] frame_marker_q;
	logic [CRC_W-1:0]  crc_mask_q;
	sfr_item_t         push_item;
	logic              push_valid;
	logic              push_ready;
	sfr_item_t         pop_item;
	logic              pop_valid;
	logic              pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_marker_q <= MARKER_RESET;
			crc_mask_q     <= MASK_RESET;
		end else if (wr_en) begin
			case (wr_index)
				CFG_FRAME_MARKER: frame_marker_q <= wr_data[BYTE_W-1:0];
				CFG_CRC_MASK:     crc_mask_q     <= wr_data[CRC_W-1:0];
				default:          crc_mask_q     <= crc_mask_q;
			endcase
		end
	end

	sfr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_marker (frame_marker_q),
		.rx_byte      (rx_byte),
		.push_item    (push_item),
		.push_valid   (push_valid),
		.push_ready   (push_ready)
	);

	sfr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_item  (push_item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_item   (pop_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	sfr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.crc_mask  (crc_mask_q),
		.pop_item  (pop_item),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.result    (result)
	);

	// A transferred byte must be waiting for the decoder in the next cycle.
	`SFR_ASSERT_NEXT(a_push_reaches_queue, rx_byte.valid && rx_byte.ready, pop_valid,
		"transferred byte missing from queue")
	// Input back-pressure only arises when the queue holds work.
	`SFR_ASSERT_NOW(a_stall_only_when_busy, rx_byte.ready || pop_valid,
		"input stalled with an empty queue")
	// Outside a frame no count and no payload are reported.
	`SFR_ASSERT_NOW(a_idle_result_clean,
		!result.valid || result.receiving ||
		(result.bytes_remaining == '0 && !result.payload_valid),
		"result outside a frame carries count or payload")

endmodule

`default_nettype wire

FILE: bench/sfr_score_pkg.sv
// Result type and scoreboard class for the frame receiver testbench.
`default_nettype none

package sfr_score_pkg;

	import sfr_pkg::*;

	typedef logic [BYTE_W-1:0] line_q_t[$];

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [BYTE_W-1:0]   payload_byte;
		logic                payload_valid;
		logic                receiving;
		logic [LEN_W-1:0]    bytes_remaining;
	} rx_result_t;

	typedef enum logic [1:0] {
		PH_WAIT,
		PH_HEADER,
		PH_PAYLOAD,
		PH_CRC
	} rx_phase_t;

	class rx_frame_scoreboard;
		logic [BYTE_W-1:0] marker;
		logic [CRC_W-1:0]  mask;

		logic              marker_pending;
		logic              in_frame;
		rx_phase_t         phase;
		logic              len_low_seen;
		logic [LEN_W-1:0]  remaining;
		logic [CRC_W-1:0]  crc;
		logic [BYTE_W-1:0] crc_high;

		rx_result_t awaited_results[$];
		int         mismatches;

		function new();
			marker = MARKER_RESET;
			mask = MASK_RESET;
			mismatches = 0;
			clear_decoder(1'b0);
		endfunction

		function void write_reg(input logic [CFG_INDEX_W-1:0] idx,
				input logic [CFG_DATA_W-1:0] data);
			if (idx == CFG_FRAME_MARKER) begin
				marker = data[BYTE_W-1:0];
			end else begin
				mask = data[CRC_W-1:0];
			end
		endfunction

		function logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] c_in,
				input logic [BYTE_W-1:0] b);
			logic [CRC_W-1:0] c;
			logic             fb;
			c = c_in;
			for (int i = 0; i < BYTE_W; i++) begin
				fb = c[0] ^ b[i];
				c = {1'b0, c[CRC_W-1:1]} ^ (fb ? mask : '0);
			end
			return c;
		endfunction

		function void clear_decoder(input logic keep_marker);
			if (!keep_marker) begin
				marker_pending = 1'b0;
			end
			in_frame = 1'b0;
			phase = PH_WAIT;
			len_low_seen = 1'b0;
			remaining = '0;
			crc = '0;
			crc_high = '0;
		endfunction

		// Handles one byte after destuffing.
		function logic [STATUS_W-1:0] decode(input logic [BYTE_W-1:0] b, output logic valid);
			valid = 1'b0;
			case (phase)
				PH_WAIT: begin
					len_low_seen = 1'b0;
					return ST_IDLE;
				end
				PH_HEADER: begin
					in_frame = 1'b1;
					if (!len_low_seen) begin
						remaining = {8'h00, b};
						len_low_seen = 1'b1;
					end else begin
						remaining = remaining | {b, 8'h00};
						phase = PH_PAYLOAD;
						crc = '0;
					end
					return ST_HEADER;
				end
				PH_PAYLOAD: begin
					remaining = remaining - 1'b1;
					crc = crc_step(crc, b);
					if (remaining == CRC_BYTES) begin
						phase = PH_CRC;
					end else if (remaining < CRC_BYTES) begin
						clear_decoder(1'b1);
						return ST_LEN_ERR;
					end
					valid = 1'b1;
					return ST_PAYLOAD;
				end
				default: begin
					if (remaining != '0) begin
						crc_high = b;
						remaining = '0;
						return ST_CRC_BYTE;
					end
					if (crc == {crc_high, b}) begin
						clear_decoder(1'b0);
						return ST_OK;
					end
					clear_decoder(1'b1);
					return ST_CRC_ERR;
				end
			endcase
		endfunction

		function void note_line_byte(input logic [BYTE_W-1:0] b);
			logic                valid;
			logic                restart;
			logic [STATUS_W-1:0] st;
			rx_result_t          want;
			valid = 1'b0;
			restart = 1'b0;
			if (b == marker) begin
				if (marker_pending) begin
					marker_pending = 1'b0;
					st = decode(b, valid);
				end else begin
					marker_pending = 1'b1;
					st = ST_MARKER;
				end
			end else begin
				// A lone marker before any other byte opens a new frame.
				if (marker_pending) begin
					restart = in_frame;
					clear_decoder(1'b0);
					phase = PH_HEADER;
					in_frame = 1'b1;
				end
				marker_pending = 1'b0;
				st = decode(b, valid);
				if (restart) begin
					st = ST_RESTART;
				end
			end
			want.status = st;
			want.payload_byte = valid ? b : '0;
			want.payload_valid = valid;
			want.receiving = in_frame;
			want.bytes_remaining = in_frame ? remaining : '0;
			awaited_results.push_back(want);
		endfunction

		function void check_result(input rx_result_t got);
			rx_result_t want;
			if (awaited_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result: status=%0d byte=%02h pv=%0b rx=%0b rem=%0d",
						got.status, got.payload_byte, got.payload_valid, got.receiving,
						got.bytes_remaining);
				end
				return;
			end
			want = awaited_results.pop_front();
			if (got.status !== want.status || got.payload_byte !== want.payload_byte ||
					got.payload_valid !== want.payload_valid ||
					got.receiving !== want.receiving ||
					got.bytes_remaining !== want.bytes_remaining) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("result mismatch: expected status=%0d byte=%02h pv=%0b rx=%0b rem=%0d",
						want.status, want.payload_byte, want.payload_valid, want.receiving,
						want.bytes_remaining);
					$display("                 actual   status=%0d byte=%02h pv=%0b rx=%0b rem=%0d",
						got.status, got.payload_byte, got.payload_valid, got.receiving,
						got.bytes_remaining);
				end
			end
		endfunction
	endclass

endpackage

`default_nettype wire

FILE: bench/tb_stuffed_frame_receiver_crc16.sv
// Testbench top for the stuffed frame receiver: stimulus, handshakes and the final verdict.
`default_nettype none

module tb_stuffed_frame_receiver_crc16;

	import sfr_pkg::*;
	import sfr_score_pkg::*;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   wr_en;
	logic [CFG_INDEX_W-1:0] wr_index;
	logic [CFG_DATA_W-1:0]  wr_data;

	sfr_byte_if   rx_if ();
	sfr_result_if res_if ();

	rx_frame_scoreboard sb;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int line_bytes_sent = 0;
	bit hold_request = 1'b0;

	stuffed_frame_receiver_crc16 u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.rx_byte  (rx_if),
		.result   (res_if)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		wr_en <= 1'b0;
		sb.write_reg(idx, data);
		@(posedge clk);
	endtask

	task automatic send_raw(input logic [BYTE_W-1:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			rx_if.valid <= 1'b0;
			@(posedge clk);
		end
		rx_if.valid <= 1'b1;
		rx_if.byte_in <= b;
		@(posedge clk);
		while (!rx_if.ready) begin
			@(posedge clk);
		end
		sb.note_line_byte(b);
		line_bytes_sent++;
	endtask

	task automatic send_line(input line_q_t line);
		foreach (line[i]) begin
			send_raw(line[i]);
		end
	endtask

	// Holds the sender back until every result it caused has come out.
	task automatic drain_results();
		rx_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.awaited_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	function automatic void push_stuffed(ref line_q_t line, input logic [BYTE_W-1:0] b);
		line.push_back(b);
		if (b == sb.marker) begin
			line.push_back(b);
		end
	endfunction

	function automatic void build_frame(input logic [LEN_W-1:0] len_field, input line_q_t payload,
			input logic [CRC_W-1:0] crc_flip, output line_q_t line);
		logic [CRC_W-1:0] c;
		line = {};
		c = '0;
		line.push_back(sb.marker);
		push_stuffed(line, len_field[7:0]);
		push_stuffed(line, len_field[15:8]);
		foreach (payload[i]) begin
			push_stuffed(line, payload[i]);
			c = sb.crc_step(c, payload[i]);
		end
		c = c ^ crc_flip;
		push_stuffed(line, c[15:8]);
		push_stuffed(line, c[7:0]);
	endfunction

	task automatic run_directed();
		line_q_t payload;
		line_q_t line;
		logic [BYTE_W-1:0] m;
		m = sb.marker;
		send_raw(8'h00);
		send_raw(8'hFF);
		// A doubled marker outside a frame is a literal byte with nothing to do.
		send_raw(m);
		send_raw(m);
		payload.push_back(m);
		build_frame(16'd3, payload, '0, line);
		send_line(line);
		// Lengths one and two end on the first payload byte.
		send_raw(m);
		send_raw(8'h01);
		send_raw(8'h00);
		send_raw(8'h55);
		send_raw(m);
		send_raw(8'h02);
		send_raw(8'h00);
		send_raw(8'h66);
		// A zero length wraps the count, so the frame stays open.
		send_raw(m);
		send_raw(8'h00);
		send_raw(8'h00);
		send_raw(8'hA5);
		// This frame restarts the open one and carries a bad CRC.
		payload = {};
		payload.push_back(8'h11);
		payload.push_back(8'h22);
		build_frame(16'd4, payload, 16'h8000, line);
		send_line(line);
	endtask

	task automatic send_random_frame();
		int               kind;
		int               n;
		int               cut;
		logic [LEN_W-1:0] len_field;
		logic [CRC_W-1:0] flip;
		line_q_t          payload;
		line_q_t          line;
		kind = $urandom_range(99);
		if (kind >= 93) begin
			repeat ($urandom_range(5, 1)) begin
				send_raw(($urandom_range(4) == 0) ? sb.marker : 8'($urandom));
			end
			return;
		end
		n = ($urandom_range(19) == 0) ? $urandom_range(60, 13) : $urandom_range(12, 1);
		for (int i = 0; i < n; i++) begin
			payload.push_back(($urandom_range(4) == 0) ? sb.marker : 8'($urandom));
		end
		len_field = 16'(n + 2);
		flip = '0;
		if (kind >= 65 && kind < 76) begin
			flip = 16'($urandom_range(65535, 1));
		end else if (kind >= 76 && kind < 86) begin
			case ($urandom_range(2))
				0: len_field = 16'($urandom_range(2));
				1: len_field = 16'(n + 2 + $urandom_range(4, 1));
				default: len_field = 16'(n + 2 - $urandom_range(n, 1));
			endcase
		end
		build_frame(len_field, payload, flip, line);
		// Cut frames are cut off by whatever comes next.
		if (kind >= 86) begin
			cut = $urandom_range(line.size() - 1, 1);
			while (line.size() > cut) begin
				void'(line.pop_back());
			end
		end
		send_line(line);
	endtask

	initial begin : result_sink
		int         hold_left;
		rx_result_t got;
		hold_left = 0;
		res_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (res_if.valid && res_if.ready) begin
				got.status = res_if.status;
				got.payload_byte = res_if.payload_byte;
				got.payload_valid = res_if.payload_valid;
				got.receiving = res_if.receiving;
				got.bytes_remaining = res_if.bytes_remaining;
				sb.check_result(got);
			end
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = 90;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin : stimulus
		int target;
		int wait_cycles;
		bit pressure_done;
		sb = new();
		arst_n <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= '0;
		wr_data <= '0;
		rx_if.valid <= 1'b0;
		rx_if.byte_in <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < 6; p++) begin
			if (p < 2) begin
				send_idle_pct = 36;
				recv_idle_pct = 67;
			end else if (p < 4) begin
				send_idle_pct = 67;
				recv_idle_pct = 36;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (p > 0) begin
				drain_results();
				repeat (4) @(posedge clk);
				case (p)
					1: begin
						write_reg(CFG_FRAME_MARKER, 16'h0000);
						write_reg(CFG_CRC_MASK, 16'hFFFF);
					end
					2: begin
						// Upper bits of the write data must not reach the marker.
						write_reg(CFG_FRAME_MARKER, 16'h5AFF);
						write_reg(CFG_CRC_MASK, 16'h0000);
					end
					3: begin
						write_reg(CFG_FRAME_MARKER, 16'($urandom));
						write_reg(CFG_CRC_MASK, 16'($urandom));
					end
					4: begin
						write_reg(CFG_FRAME_MARKER, 16'hA57E);
						write_reg(CFG_CRC_MASK, 16'h8408);
					end
					default: begin
						write_reg(CFG_FRAME_MARKER, 16'($urandom));
						write_reg(CFG_CRC_MASK, MASK_RESET);
					end
				endcase
			end else begin
				run_directed();
			end
			target = line_bytes_sent + 200;
			pressure_done = 1'b0;
			while (line_bytes_sent < target) begin
				if (!pressure_done && line_bytes_sent > target - 100) begin
					if (p == 1 || p == 5) begin
						hold_request = 1'b1;
					end else if (p == 3) begin
						drain_results();
					end
					pressure_done = 1'b1;
				end
				send_random_frame();
			end
		end

		rx_if.valid <= 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		wait_cycles = 0;
		while (sb.awaited_results.size() != 0 && wait_cycles < 5000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.awaited_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin : watchdog
		#(12 * 500000);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
